// ===== hdl/sr_pkg.sv =====
// ----------------------------------------------------------------------------
// sr_pkg: shared types and constants for the systematic resampler
// Widths of the weight path, the cumulative sums and the particle indices,
// the control state encoding and the particle count clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package sr_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int FRAC_W        = 16;                   // weight fraction bits
  localparam int WEIGHT_W      = FRAC_W + 1;           // unsigned Q1.16
  localparam int OFFSET_W      = FRAC_W;               // Q0.16 random fraction
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = IDX_W + 1;            // holds MAX_PARTICLES
  localparam int SUM_W         = 23;                   // running sum width
  localparam int CURSOR_W      = IDX_W + OFFSET_W;     // offset + slot * 1.0
  localparam int PROD_W        = CNT_W + SUM_W;        // N * cumulative sum

  localparam int S_DATA_W      = ((WEIGHT_W + OFFSET_W + 7) / 8) * 8;
  localparam int M_DATA_W      = ((IDX_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_LOAD,   // taking weights
    ST_READ,   // store read in flight
    ST_CMP     // compare cursor against cumulative sum, emit index
  } sr_state_t;

  // Clamp the register to the supported particle range
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] pc);
    logic [CNT_W-1:0] n;
    n = pc;
    if (pc == '0) begin
      n = CNT_W'(1);
    end else if (pc > CNT_W'(MAX_PARTICLES)) begin
      n = CNT_W'(MAX_PARTICLES);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/systematic_resampler_top.sv =====
// ----------------------------------------------------------------------------
// systematic_resampler_top: systematic resampler for a particle filter
// Accumulates a batch of weights into a cumulative-sum RAM, then walks the
// sums against the systematic cursor and streams out source indices.
// ----------------------------------------------------------------------------
// Weights are taken one per cycle while loading; each item adds its weight to
// the running sum and writes the sum into the cumulative RAM. The item that
// completes the batch (load count reaching the clamped particle_count N)
// starts the resampling walk with that item's random_offset; no weight is
// taken during the walk. The walk is bound by the RAM's registered read: each
// index advance passes through a read state and then a compare state, and
// each index is emitted from the compare state, which waits while the output
// is stalled. The N indices come out in slot order, tlast on the final one. A
// particle_count of 0 acts as 1 and values above 64 act as 64.
// ----------------------------------------------------------------------------
`default_nettype none

module systematic_resampler_top
  import sr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration: particle_count
  input  wire logic                cfg_wr_en,
  input  wire logic [CNT_W-1:0]    cfg_wr_data,
  // weight items
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // weight[16:0], random_offset[32:17]
  // index items
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [M_DATA_W-1:0] m_tdata,   // source_index[5:0]
  output logic                     m_tlast
);

  sr_state_t        state, state_next;
  logic [CNT_W-1:0] particle_count;
  logic [CNT_W-1:0] load_count, load_count_next;
  logic [SUM_W-1:0] running_sum, running_sum_next;
  logic [CNT_W-1:0] n_reg, n_reg_next;
  logic [OFFSET_W-1:0] offset, offset_next;
  logic [IDX_W-1:0] k, k_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic             out_valid_next;
  logic [IDX_W-1:0] out_index, out_index_next;
  logic             out_last, out_last_next;

  logic [WEIGHT_W-1:0] in_weight;
  logic [OFFSET_W-1:0] in_offset;
  logic                in_accept;
  logic [SUM_W-1:0]    sum_add;
  logic [CNT_W-1:0]    count_inc;
  logic [CNT_W-1:0]    n_m1;
  logic [CURSOR_W-1:0] cursor;
  logic [PROD_W-1:0]   scaled_cum;
  logic                advance;
  logic                out_free;

  logic             ram_wr_en;
  logic             ram_rd_en;
  logic [SUM_W-1:0] ram_rd_data;

  assign in_weight = s_tdata[WEIGHT_W-1:0];
  assign in_offset = s_tdata[WEIGHT_W+OFFSET_W-1:WEIGHT_W];
  assign s_tready  = (state == ST_LOAD);
  assign in_accept = s_tvalid && s_tready;

  assign sum_add   = running_sum + SUM_W'(in_weight);
  assign count_inc = load_count + CNT_W'(1);
  assign ram_wr_en = in_accept && !load_count[CNT_W-1];

  // cumulative sums, one entry per particle
  sr_ram #(
    .DEPTH (MAX_PARTICLES),
    .WIDTH (SUM_W)
  ) u_cum_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (load_count[IDX_W-1:0]),
    .wr_data (sum_add),
    .rd_en   (ram_rd_en),
    .rd_addr (k),
    .rd_data (ram_rd_data)
  );

  // walk compare: advance while k < N-1 and offset + slot*1.0 > N * cum[k]
  assign n_m1       = n_reg - CNT_W'(1);
  assign cursor     = {slot, offset};
  assign scaled_cum = PROD_W'(n_reg) * PROD_W'(ram_rd_data);
  assign advance    = ({1'b0, k} < n_m1) && (PROD_W'(cursor) > scaled_cum);
  assign out_free   = !m_tvalid || m_tready;

  // next state and datapath
  always_comb begin
    state_next       = state;
    load_count_next  = load_count;
    running_sum_next = running_sum;
    n_reg_next       = n_reg;
    offset_next      = offset;
    k_next           = k;
    slot_next        = slot;
    out_valid_next   = m_tvalid && !m_tready;
    out_index_next   = out_index;
    out_last_next    = out_last;
    ram_rd_en        = 1'b0;

    unique case (state)
      ST_LOAD: begin
        if (in_accept) begin
          running_sum_next = sum_add;
          load_count_next  = count_inc;
          if (count_inc >= eff_count(particle_count)) begin
            n_reg_next  = eff_count(particle_count);
            offset_next = in_offset;
            k_next      = '0;
            slot_next   = '0;
            state_next  = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_rd_en  = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (advance) begin
          k_next     = k + IDX_W'(1);
          state_next = ST_READ;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_index_next = k;
          out_last_next  = ({1'b0, slot} == n_m1);
          if ({1'b0, slot} == n_m1) begin
            load_count_next  = '0;
            running_sum_next = '0;
            state_next       = ST_LOAD;
          end else begin
            slot_next = slot + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      particle_count <= CNT_W'(MAX_PARTICLES);
      load_count     <= '0;
      running_sum    <= '0;
      k              <= '0;
      slot           <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state       <= state_next;
      load_count  <= load_count_next;
      running_sum <= running_sum_next;
      k           <= k_next;
      slot        <= slot_next;
      m_tvalid    <= out_valid_next;
      if (cfg_wr_en) begin
        particle_count <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_reg     <= n_reg_next;
    offset    <= offset_next;
    out_index <= out_index_next;
    out_last  <= out_last_next;
  end

  assign m_tdata = M_DATA_W'(out_index);
  assign m_tlast = out_last;

endmodule

`default_nettype wire

// ===== hdl/sr_ram.sv =====
// ----------------------------------------------------------------------------
// sr_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 23
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for systematic_resampler_top
// Streams weight items into the resampler and checks every source index
// against an in-bench predictor that keeps its own cumulative sums. Directed
// batches cover the count clamp, a count change in the middle of a batch and
// the weight extremes. Random batches follow, mostly normalized weights with
// random offsets, some noise and some broken batches, with random idle bursts
// on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import sr_pkg::*;

  localparam int RANDOM_ITEMS  = 460;
  localparam int QUIET_ITEMS   = 60;      // final stretch without idling
  localparam int SETTLE_CYCLES = 8;       // walk is done once the last index is out
  localparam int END_CYCLES    = 3 * MAX_PARTICLES + 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(1) << FRAC_W;
  localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = '1;

  typedef struct {
    logic [IDX_W-1:0] src_index;
    logic             last;
  } pick_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CNT_W-1:0]    cfg_wr_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // weight[16:0], random_offset[32:17]
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // source_index[5:0]
  logic                m_tlast;

  // predictor state
  logic [CNT_W-1:0] count_reg;
  logic [SUM_W-1:0] cum_sums [MAX_PARTICLES];
  logic [CNT_W-1:0] load_fill;
  logic [SUM_W-1:0] weight_sum;
  pick_t            expected_picks[$];

  int  mismatches;
  int  items_sent;
  int  cycle_count;
  int  sink_gap;
  bit  src_idle_on;
  bit  sink_idle_on;

  systematic_resampler_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("systematic_resampler_top test failed");
      $finish;
    end
  end

  // 0 acts as 1, above MAX_PARTICLES acts as MAX_PARTICLES
  function automatic int clamp_count(input logic [CNT_W-1:0] c);
    if (c == '0) return 1;
    if (c > MAX_PARTICLES) return MAX_PARTICLES;
    return int'(c);
  endfunction

  // Add one weight to the batch; on the batch's last weight, walk the
  // cumulative sums and queue one source index per output slot.
  task automatic predict_resample(input logic [WEIGHT_W-1:0] w,
                                  input logic [OFFSET_W-1:0] off);
    int               n;
    int               k;
    int               slot;
    longint unsigned  cursor;
    pick_t            p;
    n = clamp_count(count_reg);
    weight_sum = weight_sum + SUM_W'(w);
    if (load_fill < MAX_PARTICLES) cum_sums[load_fill[IDX_W-1:0]] = weight_sum;
    load_fill = load_fill + 1'b1;
    if (int'(load_fill) >= n) begin
      k = 0;
      for (slot = 0; slot < n; slot++) begin
        cursor = longint'(off) + (longint'(slot) << FRAC_W);
        while (k < n - 1 && cursor > longint'(n) * longint'(cum_sums[IDX_W'(k)])) k++;
        p.src_index = IDX_W'(k);
        p.last      = (slot == n - 1);
        expected_picks.push_back(p);
      end
      load_fill  = '0;
      weight_sum = '0;
    end
  endtask

  // one weight item, with an optional idle burst ahead of it
  task automatic send_weight(input logic [WEIGHT_W-1:0] w, input logic [OFFSET_W-1:0] off);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'({off, w});
    do @(posedge clk); while (!s_tready);
    predict_resample(w, off);
    items_sent++;
  endtask

  // drop valid, wait for every queued index, then let the block settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_particle_count(input logic [CNT_W-1:0] c);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    count_reg = c;
  endtask

  // mostly small counts, now and then the full size or out-of-range values
  function automatic logic [CNT_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return CNT_W'($urandom_range(1, 16));
    if (roll < 75) return CNT_W'($urandom_range(17, MAX_PARTICLES - 1));
    if (roll < 85) return CNT_W'(MAX_PARTICLES);
    if (roll < 92) return CNT_W'($urandom_range(MAX_PARTICLES + 1, 127));
    return '0;
  endfunction

  // n weights summing exactly to 1.0, smooth or spiky
  task automatic send_normalized_batch(input int n);
    int                  raw [MAX_PARTICLES];
    int                  total;
    int                  given;
    int                  i;
    bit                  spiky;
    logic [WEIGHT_W-1:0] w;
    spiky = ($urandom_range(0, 2) == 0);
    total = 0;
    for (i = 0; i < n; i++) begin
      if (spiky) raw[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5000) : 0;
      else       raw[i] = $urandom_range(0, 1000);
      total += raw[i];
    end
    if (total == 0) begin
      raw[n-1] = 1;
      total    = 1;
    end
    given = 0;
    for (i = 0; i < n; i++) begin
      if (i == n - 1) w = WEIGHT_W'(65536 - given);
      else            w = WEIGHT_W'((raw[i] * 65536) / total);
      given += int'(w);
      send_weight(w, OFFSET_W'($urandom));
    end
  endtask

  // unnormalized weights across the whole 17-bit range
  task automatic send_noise_weights(input int count);
    int                  i;
    int                  roll;
    logic [WEIGHT_W-1:0] w;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0)      w = '0;
      else if (roll == 1) w = MAX_WEIGHT;
      else if (roll == 2) w = ONE;
      else                w = WEIGHT_W'($urandom);
      send_weight(w, OFFSET_W'($urandom));
    end
  endtask

  // reset count is 64: three weights must not fire; lowering the count to 2
  // then fires on the next weight with the new count
  task automatic test_reset_count();
    send_weight(ONE >> 2, 16'h1234);
    send_weight(ONE >> 1, 16'hABCD);
    send_weight(ONE >> 2, 16'h0001);
    wait_drained();
    set_particle_count(CNT_W'(2));
    send_weight(ONE >> 2, 16'h8000);
    wait_drained();
  endtask

  // count 0 behaves as a single particle
  task automatic test_count_zero();
    set_particle_count('0);
    send_weight(ONE, 16'hFFFF);
    send_weight('0, 16'h0000);
    wait_drained();
  endtask

  // weight and offset extremes on a batch of four
  task automatic test_extreme_weights();
    set_particle_count(CNT_W'(4));
    // all mass on the last particle, largest offset
    send_weight('0, 16'h0000);
    send_weight('0, 16'h0000);
    send_weight('0, 16'h0000);
    send_weight(ONE, 16'hFFFF);
    // all mass on the first particle, zero offset
    send_weight(ONE, 16'hFFFF);
    send_weight('0, 16'hFFFF);
    send_weight('0, 16'hFFFF);
    send_weight('0, 16'h0000);
    // even weights: cursor lands exactly on every boundary
    repeat (4) send_weight(ONE >> 2, 16'h0000);
    // weights above 1.0, sums above one
    send_weight(MAX_WEIGHT, 16'h5555);
    send_weight(MAX_WEIGHT, 16'hAAAA);
    send_weight(MAX_WEIGHT, 16'h0F0F);
    send_weight(MAX_WEIGHT, 16'h8000);
    wait_drained();
  endtask

  // random batches, changing the count between them
  task automatic test_random_batches();
    int start_items;
    int phase;
    int n;
    int roll;
    bit force_cfg;
    start_items = items_sent;
    phase       = 0;
    force_cfg   = 1'b0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if (items_sent - start_items >= RANDOM_ITEMS - QUIET_ITEMS) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end else begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (phase == 0)
        set_particle_count(CNT_W'(127));
      else if (phase == 1)
        set_particle_count(CNT_W'(MAX_PARTICLES));
      else if (force_cfg || $urandom_range(0, 2) == 0)
        set_particle_count(pick_count());
      force_cfg = 1'b0;
      n    = clamp_count(count_reg);
      roll = $urandom_range(0, 19);
      if (roll < 15) begin
        send_normalized_batch(n);
      end else if (roll < 18 || n == 1) begin
        send_noise_weights(n);
      end else begin
        // broken batch: stop part way, the next phase changes the count
        send_noise_weights($urandom_range(1, n - 1));
        force_cfg = 1'b1;
      end
      wait_drained();
      phase++;
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // output stall bursts
  always @(posedge clk) begin
    if (rst || !sink_idle_on) begin
      m_tready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap = sink_gap - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each index item with the oldest expectation
  always @(posedge clk) begin
    pick_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_picks.size() == 0) begin
        note_mismatch($sformatf("unexpected index %0d last %0b",
                                m_tdata[IDX_W-1:0], m_tlast));
      end else begin
        want = expected_picks.pop_front();
        if (m_tdata[IDX_W-1:0] !== want.src_index || m_tlast !== want.last)
          note_mismatch($sformatf("index exp %0d got %0d, last exp %0b got %0b",
                                  want.src_index, m_tdata[IDX_W-1:0], want.last, m_tlast));
      end
    end
  end

  // sequence
  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b1;
    sink_gap     = 0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    mismatches   = 0;
    items_sent   = 0;
    cycle_count  = 0;
    count_reg    = CNT_W'(MAX_PARTICLES);
    load_fill    = '0;
    weight_sum   = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_count();
    test_count_zero();
    test_extreme_weights();
    test_random_batches();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("systematic_resampler_top test passed");
    end else begin
      $display("systematic_resampler_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
